[rtl/sorted_reference_row_range_tracker_top_assert.svh]
// Assertion macros used by the range tracker RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SORTED_REFERENCE_ROW_RANGE_TRACKER_TOP_ASSERT_SVH
`define SORTED_REFERENCE_ROW_RANGE_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held low.
`define SRRT_ASSERT_IMPLIES(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("srrt assertion failed");

// Next-cycle implication, disabled while reset is held low.
`define SRRT_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("srrt assertion failed");

`endif

[rtl/srrt_pkg.sv]
// Types and codes of the sorted reference row range tracker.
// Used by every module of the block; depends on nothing.
package srrt_pkg;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic CFG_REF_COUNT = 1'b0;
  localparam logic CFG_TRACK_EN  = 1'b1;

  localparam int ROW_W = 31;

  typedef enum logic [2:0] {
    ST_OK                    = 3'd0,
    ST_MAPPED_AFTER_UNMAPPED = 3'd1,
    ST_REVISITED             = 3'd2,
    ST_POS_DECREASED         = 3'd3,
    ST_OUT_OF_RANGE          = 3'd4,
    ST_ABANDONED             = 3'd5
  } status_t;

  typedef struct packed {
    logic               opcode;
    logic signed [10:0] ref_id;
    logic signed [31:0] position;
    logic [ROW_W-1:0]   row;
  } item_t;

  typedef struct packed {
    logic             started;
    logic [ROW_W-1:0] begin_row;
    logic [ROW_W-1:0] end_row;
  } entry_t;

  typedef struct packed {
    logic signed [10:0] prev_ref;
    logic signed [31:0] prev_pos;
    logic               sorted;
    logic               unm_started;
  } track_state_t;

  typedef struct packed {
    status_t          status;
    logic             sorted_nxt;
    logic             upd;
    logic             upd_unm;
    logic             present;
    logic [ROW_W-1:0] rd_begin;
    logic [ROW_W-1:0] rd_end;
    entry_t           wr_entry;
  } decision_t;

endpackage

[rtl/srrt_entry_table.sv]
// Per-reference row range table: one write port, one registered read port.
// Sweeps every row to the not-started value after reset. Uses srrt_pkg.
module srrt_entry_table #(
  parameter int MAX_REFERENCES = 1024,
  parameter int SLOT_W = 11
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [SLOT_W-1:0]   rd_slot,
  output srrt_pkg::entry_t    rd_entry,
  input  logic                wr_en,
  input  logic [SLOT_W-1:0]   wr_slot,
  input  srrt_pkg::entry_t    wr_entry,
  output logic                busy
);

  localparam int DEPTH = MAX_REFERENCES + 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_REFERENCES);

  srrt_pkg::entry_t mem [DEPTH];
  srrt_pkg::entry_t rd_q_r;
  logic [SLOT_W-1:0] clr_idx_r;
  logic              busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_idx_r <= '0;
    end else if (busy_r) begin
      if (clr_idx_r == LAST_SLOT) begin
        busy_r <= 1'b0;
      end else begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (wr_en) begin
      mem[wr_slot] <= wr_entry;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_slot];
    end
  end

  assign rd_entry = rd_q_r;
  assign busy     = busy_r;

endmodule

[rtl/srrt_check.sv]
// Order check and entry update decision for one registered item.
// Combinational; uses srrt_pkg types.
module srrt_check #(
  parameter int MAX_REFERENCES = 1024,
  parameter int SLOT_W = 11
) (
  input  srrt_pkg::item_t        item,
  input  srrt_pkg::track_state_t state,
  input  logic                   tracking_en,
  input  logic [10:0]            ref_count,
  input  srrt_pkg::entry_t       mem_entry,
  input  logic                   cur_valid,
  input  logic [SLOT_W-1:0]      cur_slot,
  input  srrt_pkg::entry_t       cur_entry,
  output srrt_pkg::decision_t    dec,
  output logic [SLOT_W-1:0]      wr_slot
);

  localparam logic [SLOT_W-1:0] UNM_SLOT = SLOT_W'(MAX_REFERENCES);

  logic [31:0]               id_wide;
  logic                      id_neg;
  logic                      id_unm;
  logic                      id_in_range;
  logic                      slot_ok;
  logic [SLOT_W-1:0]         slot;
  logic                      hit;
  srrt_pkg::entry_t          ent;
  logic [srrt_pkg::ROW_W-1:0] end_sat;

  always_comb begin
    id_wide     = 32'(unsigned'(item.ref_id));
    id_neg      = item.ref_id[10];
    id_unm      = &item.ref_id;
    id_in_range = !id_neg && (id_wide < 32'(ref_count)) && (id_wide < 32'(MAX_REFERENCES));
    slot        = id_unm ? UNM_SLOT : id_wide[SLOT_W-1:0];
    slot_ok     = id_unm || id_in_range;
    // The entry of the current run lives in registers; the table copy may lag.
    hit         = cur_valid && (cur_slot == slot);
    ent         = hit ? cur_entry : mem_entry;
    end_sat     = (&item.row) ? item.row : item.row + 1'b1;

    dec                    = '0;
    dec.status             = srrt_pkg::ST_OK;
    dec.sorted_nxt         = state.sorted;
    dec.upd_unm            = id_unm;
    dec.wr_entry.started   = 1'b1;
    dec.wr_entry.begin_row = ent.started ? ent.begin_row : item.row;
    dec.wr_entry.end_row   = end_sat;
    wr_slot                = slot;

    if (!tracking_en || !state.sorted) begin
      dec.status = srrt_pkg::ST_ABANDONED;
    end else if (item.opcode == srrt_pkg::OP_ADD) begin
      if (item.ref_id != state.prev_ref) begin
        if (!id_neg) begin
          if (state.unm_started) begin
            dec.status = srrt_pkg::ST_MAPPED_AFTER_UNMAPPED;
          end else if (!id_in_range) begin
            dec.status = srrt_pkg::ST_OUT_OF_RANGE;
          end else if (ent.started) begin
            dec.status = srrt_pkg::ST_REVISITED;
          end
        end else if (!id_unm) begin
          dec.status = srrt_pkg::ST_OUT_OF_RANGE;
        end
      end else begin
        if (!id_neg && ($signed(state.prev_pos) > $signed(item.position))) begin
          dec.status = srrt_pkg::ST_POS_DECREASED;
        end else if (!slot_ok) begin
          dec.status = srrt_pkg::ST_OUT_OF_RANGE;
        end
      end
      if (dec.status == srrt_pkg::ST_OK) begin
        dec.upd = 1'b1;
      end else begin
        dec.sorted_nxt = 1'b0;
      end
    end else begin
      if (!slot_ok) begin
        dec.status = srrt_pkg::ST_OUT_OF_RANGE;
      end else if (ent.started) begin
        dec.present  = 1'b1;
        dec.rd_begin = ent.begin_row;
        dec.rd_end   = ent.end_row;
      end
    end
  end

endmodule

[rtl/sorted_reference_row_range_tracker_top.sv]
// Sorted reference row range tracker, top level. Uses srrt_pkg, srrt_check, srrt_entry_table.
// An accepted beat is held in the input register; its result is registered in the result register.
// Throughput: one beat per cycle while out_tready holds and the entry table is not being swept.
// Reset: synchronous, active low. Afterwards a clearing pass over all MAX_REFERENCES + 1 slots
// sweeps the entry table, during which in_tready stays low; configuration is taken as ever.
`include "sorted_reference_row_range_tracker_top_assert.svh"

module sorted_reference_row_range_tracker_top #(
  parameter int MAX_REFERENCES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data,
  // Input beats.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,  // ref_id[10:0], position[42:11], row[73:43], zero[79:74]
  input  logic [0:0]  in_tuser,  // opcode[0]
  // Result beats.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata, // still_sorted[0], entry_present[1],
                                 // entry_begin_row[32:2], entry_end_row[63:33]
  output logic [2:0]  out_tuser  // status[2:0]
);

  // One table slot per reference plus the unmapped slot at index MAX_REFERENCES.
  localparam int SLOT_W = $clog2(MAX_REFERENCES + 1);
  localparam logic [SLOT_W-1:0] UNM_SLOT = SLOT_W'(MAX_REFERENCES);

  // Configuration registers.
  logic [10:0] ref_count_r;
  logic        tracking_en_r;

  // Input register stage.
  logic            s1_valid_r;
  srrt_pkg::item_t s1_item_r;

  // Tracking state. The entry of the reference currently being visited is
  // mirrored in cur_* so that back-to-back records of one run never wait for
  // the table: every table write targets that slot, and lookups of it are
  // forwarded from here.
  srrt_pkg::track_state_t state_r;
  logic                   cur_valid_r;
  logic [SLOT_W-1:0]      cur_slot_r;
  srrt_pkg::entry_t       cur_entry_r;

  // Result register.
  logic              out_valid_r;
  srrt_pkg::status_t out_status_r;
  logic [63:0]       out_data_r;

  logic                advance;
  logic                fire;
  logic                in_accept;
  logic                add_rejected;
  logic                tbl_busy;
  srrt_pkg::entry_t    tbl_rd_entry;
  logic [SLOT_W-1:0]   rd_slot;
  logic [31:0]         in_id_wide;
  srrt_pkg::decision_t dec;
  logic [SLOT_W-1:0]   wr_slot;

  // The result register frees up when it is empty or being taken; the input
  // register then hands its item across, so a new beat can enter every cycle once the sweep is over.
  assign advance   = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && advance;
  assign in_tready = !tbl_busy && (!s1_valid_r || advance);
  assign in_accept = in_tvalid && in_tready;

  // An add refused for broken order or an out-of-range id while tracking is still running.
  assign add_rejected = fire && (s1_item_r.opcode == srrt_pkg::OP_ADD) &&
                        (dec.status != srrt_pkg::ST_OK) &&
                        (dec.status != srrt_pkg::ST_ABANDONED);

  // The table is read as the beat is accepted, so its entry is ready when
  // the beat sits in the input register. Ids the table cannot hold read the
  // unmapped slot; such reads are never used.
  always_comb begin
    in_id_wide = 32'(in_tdata[10:0]);
    if ((&in_tdata[10:0]) || in_tdata[10] || (in_id_wide >= 32'(MAX_REFERENCES))) begin
      rd_slot = UNM_SLOT;
    end else begin
      rd_slot = in_id_wide[SLOT_W-1:0];
    end
  end

  srrt_entry_table #(
    .MAX_REFERENCES(MAX_REFERENCES),
    .SLOT_W        (SLOT_W)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_accept),
    .rd_slot (rd_slot),
    .rd_entry(tbl_rd_entry),
    .wr_en   (fire && dec.upd),
    .wr_slot (wr_slot),
    .wr_entry(dec.wr_entry),
    .busy    (tbl_busy)
  );

  srrt_check #(
    .MAX_REFERENCES(MAX_REFERENCES),
    .SLOT_W        (SLOT_W)
  ) u_check (
    .item       (s1_item_r),
    .state      (state_r),
    .tracking_en(tracking_en_r),
    .ref_count  (ref_count_r),
    .mem_entry  (tbl_rd_entry),
    .cur_valid  (cur_valid_r),
    .cur_slot   (cur_slot_r),
    .cur_entry  (cur_entry_r),
    .dec        (dec),
    .wr_slot    (wr_slot)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_count_r   <= 11'd0;
      tracking_en_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        srrt_pkg::CFG_REF_COUNT: ref_count_r   <= cfg_data;
        srrt_pkg::CFG_TRACK_EN:  tracking_en_r <= cfg_data[0];
        default:                 ref_count_r   <= ref_count_r;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= '{opcode:   in_tuser[0],
                     ref_id:   in_tdata[10:0],
                     position: in_tdata[42:11],
                     row:      in_tdata[73:43]};
    end
  end

  // Tracking state. A rejected add only clears the sorted flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.prev_ref    <= -11'sd1;
      state_r.prev_pos    <= -32'sd1;
      state_r.sorted      <= 1'b1;
      state_r.unm_started <= 1'b0;
      cur_valid_r         <= 1'b0;
    end else if (fire) begin
      state_r.sorted <= dec.sorted_nxt;
      if (dec.upd) begin
        state_r.prev_ref    <= s1_item_r.ref_id;
        state_r.prev_pos    <= s1_item_r.position;
        state_r.unm_started <= state_r.unm_started || dec.upd_unm;
        cur_valid_r         <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && dec.upd) begin
      cur_slot_r  <= wr_slot;
      cur_entry_r <= dec.wr_entry;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status_r <= dec.status;
      out_data_r   <= {dec.rd_end, dec.rd_begin, dec.present, dec.sorted_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  // No beat may enter while the table is still being swept.
  `SRRT_ASSERT_IMPLIES(a_clear_blocks_input, clk, rst_n, tbl_busy, !in_tready)
  // Once cleared, the sorted flag stays cleared until reset.
  `SRRT_ASSERT_NEXT(a_sorted_sticky, clk, rst_n, !state_r.sorted, !state_r.sorted)
  // A rejected add clears the flag on the following cycle.
  `SRRT_ASSERT_NEXT(a_violation_clears, clk, rst_n, add_rejected, !state_r.sorted)
  // Every item handed across shows up in the result register.
  `SRRT_ASSERT_NEXT(a_result_follows, clk, rst_n, fire, out_valid_r)

endmodule
